[sv/qph_pkg.sv]
// ============================================================================
// qph_pkg
// Shared types, constants and the control store for the quadratic-probe hash
// insert block.
// ============================================================================
package qph_pkg;

  // Store geometry.
  localparam int TABLE_DEPTH = 128;
  localparam int KEY_W       = 17;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int MOD_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(KEY_W + 1);

  // Fixed field widths of the channels.
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;
  localparam int TSIZE_W  = 8;

  localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(127);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                occupied;
    logic [KEY_W-1:0]    stored_key;
  } rsp_t;

  // Remainder unit status.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_status_t;

  // Control word fields.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_CLEAR,
    ACT_RD_ADDR,
    ACT_RD_DATA,
    ACT_DIV_START,
    ACT_HOME,
    ACT_ADVANCE,
    ACT_DROP,
    ACT_WRITE,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_WAIT,
    JMP_UNLESS,
    JMP_IF,
    JMP_DISPATCH
  } jmp_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_DIV_DONE,
    COND_EMPTY,
    COND_DROP,
    COND_OUT_FREE
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    act_t  act;
    jmp_t  jmp;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Program addresses.
  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_CLR   = 4'd1;
  localparam step_t S_RD    = 4'd2;
  localparam step_t S_RD2   = 4'd3;
  localparam step_t S_INS   = 4'd4;
  localparam step_t S_DIV   = 4'd5;
  localparam step_t S_HOME  = 4'd6;
  localparam step_t S_PROBE = 4'd7;
  localparam step_t S_STEP  = 4'd8;
  localparam step_t S_DROP  = 4'd9;
  localparam step_t S_WRITE = 4'd10;
  localparam step_t S_EMIT  = 4'd11;

  // The control store. Unused addresses fall back to the idle step.
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    begin
      unique case (pc)
        S_IDLE:  w = '{ACT_ACCEPT,    JMP_DISPATCH, COND_NONE,     S_IDLE};
        S_CLR:   w = '{ACT_CLEAR,     JMP_GOTO,     COND_NONE,     S_EMIT};
        S_RD:    w = '{ACT_RD_ADDR,   JMP_NEXT,     COND_NONE,     S_IDLE};
        S_RD2:   w = '{ACT_RD_DATA,   JMP_GOTO,     COND_NONE,     S_EMIT};
        S_INS:   w = '{ACT_DIV_START, JMP_NEXT,     COND_NONE,     S_IDLE};
        S_DIV:   w = '{ACT_NONE,      JMP_WAIT,     COND_DIV_DONE, S_HOME};
        S_HOME:  w = '{ACT_HOME,      JMP_NEXT,     COND_NONE,     S_IDLE};
        S_PROBE: w = '{ACT_NONE,      JMP_IF,       COND_EMPTY,    S_WRITE};
        S_STEP:  w = '{ACT_ADVANCE,   JMP_UNLESS,   COND_DROP,     S_PROBE};
        S_DROP:  w = '{ACT_DROP,      JMP_GOTO,     COND_NONE,     S_EMIT};
        S_WRITE: w = '{ACT_WRITE,     JMP_GOTO,     COND_NONE,     S_EMIT};
        S_EMIT:  w = '{ACT_EMIT,      JMP_WAIT,     COND_OUT_FREE, S_IDLE};
        default: w = '{ACT_NONE,      JMP_GOTO,     COND_NONE,     S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

[sv/qph_ram.sv]
// ============================================================================
// qph_ram
// Generic single-port RAM with a registered read.
// ============================================================================
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share the one address port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/qph_rem.sv]
// ============================================================================
// qph_rem
// Bit-serial remainder unit: key mod modulus, one key bit per cycle.
// ============================================================================
module qph_rem
  import qph_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [MOD_W-1:0]  modulus,
  output div_status_t       status
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [KEY_W-1:0]     shreg;
  logic [IDX_W-1:0]     rem;
  logic [IDX_W:0]       trial;
  logic [IDX_W:0]       trial_sub;

  // Shift the next key bit into the partial remainder and reduce once.
  always_comb begin
    trial     = {rem, shreg[KEY_W-1]};
    trial_sub = trial - (IDX_W+1)'(modulus);
  end

  // Control: busy until every key bit has been shifted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(KEY_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= key;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[KEY_W-2:0], 1'b0};
      if (trial >= (IDX_W+1)'(modulus)) begin
        rem <= trial_sub[IDX_W-1:0];
      end else begin
        rem <= trial[IDX_W-1:0];
      end
    end
  end

  assign status.done = !busy;
  assign status.rem  = rem;

endmodule

[sv/quadratic_probe_hash_insert.sv]
// ============================================================================
// quadratic_probe_hash_insert
// Open-addressing hash table with quadratic probing, run by a small
// microcoded sequencer over a remainder unit, a probe datapath and a RAM.
// ============================================================================
//
//  Channel  Signals                     Carries
//  -------  --------------------------  ------------------------------------
//  req      req_valid, req_ready, req   command beat: cmd, key, slot_index
//  rsp      rsp_valid, rsp_ready, rsp   result beat: status, slot, occupied,
//                                       stored_key
//  cfg      cfg_we, cfg_data            table_size register write
//
// An insert first finds its home slot with the bit-serial remainder (one key
// bit a cycle), then walks the two-step probe loop once per occupied slot
// probed, until it places the key or drops it.
// Reset empties every slot at once through per-slot valid flops and sets
// table_size to 127. A result that is not taken holds the sequencer in its
// last step; one further command may be accepted meanwhile.
//
module quadratic_probe_hash_insert
  import qph_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [TSIZE_W-1:0] cfg_data
);

  // Sequencer.
  step_t  pc;
  step_t  pc_next;
  ucode_t uw;

  // Registers.
  logic [TSIZE_W-1:0]     table_size;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [MOD_W-1:0]       modulus;
  logic [KEY_W-1:0]       key;
  logic [SLOT_W-1:0]      slot_index;
  logic [IDX_W-1:0]       pos;
  logic [IDX_W-1:0]       home;
  logic [MOD_W-1:0]       delta;
  logic [MOD_W:0]         j;
  rsp_t                   res;

  // Datapath wires.
  logic [MOD_W-1:0]  modulus_next;
  logic [MOD_W:0]    pos_sum;
  logic [IDX_W-1:0]  pos_next;
  logic [MOD_W:0]    delta_sum;
  logic [MOD_W-1:0]  delta_next;
  logic              drop;
  logic              cond_true;
  logic              out_free;
  logic              accept;
  div_status_t       div_st;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [KEY_W-1:0]  ram_q;

  assign uw        = ucode_rom(pc);
  assign req_ready = (uw.act == ACT_ACCEPT);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // Saturate the table size into the legal modulus range.
  always_comb begin
    if (table_size < TSIZE_W'(2)) begin
      modulus_next = MOD_W'(2);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      modulus_next = MOD_W'(TABLE_DEPTH);
    end else begin
      modulus_next = MOD_W'(table_size);
    end
  end

  // Next probe position: the step between squares grows by two each time.
  always_comb begin
    pos_sum   = (MOD_W+1)'(pos) + (MOD_W+1)'(delta);
    delta_sum = (MOD_W+1)'(delta) + (MOD_W+1)'(2);
    if (pos_sum >= (MOD_W+1)'(modulus)) begin
      pos_next = IDX_W'(pos_sum - (MOD_W+1)'(modulus));
    end else begin
      pos_next = IDX_W'(pos_sum);
    end
    if (delta_sum >= (MOD_W+1)'(modulus)) begin
      delta_next = MOD_W'(delta_sum - (MOD_W+1)'(modulus));
    end else begin
      delta_next = MOD_W'(delta_sum);
    end
    drop = ((j >= (MOD_W+1)'(2)) && (pos_next == home)) ||
           (j > (MOD_W+1)'(modulus));
  end

  // Condition select.
  always_comb begin
    unique case (uw.cond)
      COND_DIV_DONE: cond_true = div_st.done;
      COND_EMPTY:    cond_true = !slot_valid[pos];
      COND_DROP:     cond_true = drop;
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
  end

  // Next step of the program.
  always_comb begin
    pc_next = pc;
    unique case (uw.jmp)
      JMP_NEXT:   pc_next = pc + 1'b1;
      JMP_GOTO:   pc_next = uw.target;
      JMP_WAIT:   pc_next = cond_true ? uw.target : pc;
      JMP_IF:     pc_next = cond_true ? uw.target : pc + 1'b1;
      JMP_UNLESS: pc_next = cond_true ? pc + 1'b1 : uw.target;
      JMP_DISPATCH: begin
        if (req_valid) begin
          case (req.cmd)
            CMD_CLEAR:  pc_next = S_CLR;
            CMD_INSERT: pc_next = S_INS;
            CMD_READ:   pc_next = S_RD;
            default:    pc_next = S_IDLE;
          endcase
        end
      end
      default:    pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TSIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  // Per-slot occupancy flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (uw.act == ACT_CLEAR) begin
      slot_valid <= '0;
    end else if (uw.act == ACT_WRITE) begin
      slot_valid[pos] <= 1'b1;
    end
  end

  // Command capture, probe registers and result staging.
  always_ff @(posedge clk) begin
    case (uw.act)
      ACT_ACCEPT: begin
        if (accept) begin
          key        <= req.key;
          slot_index <= req.slot_index;
          modulus    <= modulus_next;
        end
      end
      ACT_CLEAR: begin
        res <= '{ST_CLEARED, '0, 1'b0, '0};
      end
      ACT_RD_DATA: begin
        res.status     <= ST_READ;
        res.slot       <= slot_index;
        res.occupied   <= slot_valid[IDX_W'(slot_index)];
        res.stored_key <= slot_valid[IDX_W'(slot_index)] ? ram_q : '0;
      end
      ACT_HOME: begin
        pos   <= div_st.rem;
        home  <= div_st.rem;
        delta <= MOD_W'(1);
        j     <= (MOD_W+1)'(1);
      end
      ACT_ADVANCE: begin
        pos   <= pos_next;
        delta <= delta_next;
        j     <= j + 1'b1;
      end
      ACT_DROP: begin
        res <= '{ST_DROPPED, '0, 1'b0, '0};
      end
      ACT_WRITE: begin
        res <= '{ST_INSERTED, SLOT_W'(pos), 1'b0, '0};
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((uw.act == ACT_EMIT) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.act == ACT_EMIT) && out_free) begin
      rsp <= res;
    end
  end

  // Remainder unit for the home slot.
  qph_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (uw.act == ACT_DIV_START),
    .key     (key),
    .modulus (modulus),
    .status  (div_st)
  );

  // Key store.
  assign ram_we   = (uw.act == ACT_WRITE);
  assign ram_addr = (uw.act == ACT_WRITE) ? pos : IDX_W'(slot_index);

  qph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (key),
    .rdata (ram_q)
  );

endmodule

[tb/quadratic_probe_hash_insert_test.sv]
// ============================================================================
// quadratic_probe_hash_insert_test
// Self-checking bench for the quadratic-probe hash insert block. A shadow
// table predicts every result beat as commands are accepted. The checker
// compares each result beat, field by field, with the oldest prediction. The
// stimulus covers directed corner cases, then random phases over several
// table sizes, with random request gaps and random result back-pressure.
// ============================================================================
module quadratic_probe_hash_insert_test;
  import qph_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int IDLE_PCT      = 24;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;
  logic               cfg_we    = 1'b0;
  logic [TSIZE_W-1:0] cfg_data  = '0;

  // Shadow copy of the table and of the size register.
  logic               shadow_valid [TABLE_DEPTH];
  logic [KEY_W-1:0]   shadow_key   [TABLE_DEPTH];
  logic [TSIZE_W-1:0] shadow_tsize;

  rsp_t pending_rsp [$];
  rsp_t want;
  int   mismatches = 0;
  bit   calm       = 1'b0;

  quadratic_probe_hash_insert uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // The modulus in use, with the register saturated into the range 2 to the store depth.
  function automatic int table_modulus();
    int m;
    m = shadow_tsize;
    if (m < 2) m = 2;
    if (m > TABLE_DEPTH) m = TABLE_DEPTH;
    return m;
  endfunction

  function automatic void empty_shadow();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
    end
  endfunction

  // Works out the result beat of one command and updates the shadow table.
  function automatic void predict_command(input req_t item);
    rsp_t r;
    int   m, kv, home, pos, j;
    bit   dropped;
    r = '0;
    case (item.cmd)
      CMD_CLEAR: begin
        empty_shadow();
        r.status = ST_CLEARED;
        pending_rsp.push_back(r);
      end
      CMD_INSERT: begin
        m       = table_modulus();
        kv      = item.key;
        home    = kv % m;
        pos     = home;
        dropped = 1'b0;
        j       = 1;
        while (!dropped && shadow_valid[pos]) begin
          pos = (kv + j * j) % m;
          if (j >= 2 && pos == home) dropped = 1'b1;
          if (j > m) dropped = 1'b1;
          j++;
        end
        if (dropped) begin
          r.status = ST_DROPPED;
        end else begin
          shadow_valid[pos] = 1'b1;
          shadow_key[pos]   = item.key;
          r.status          = ST_INSERTED;
          r.slot            = SLOT_W'(pos);
        end
        pending_rsp.push_back(r);
      end
      CMD_READ: begin
        r.status = ST_READ;
        r.slot   = item.slot_index;
        if (shadow_valid[item.slot_index]) begin
          r.occupied   = 1'b1;
          r.stored_key = shadow_key[item.slot_index];
        end
        pending_rsp.push_back(r);
      end
      default: begin
        // Unknown command: accepted but yields no beat.
      end
    endcase
  endfunction

  function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
                                    input logic [KEY_W-1:0] key,
                                    input logic [SLOT_W-1:0] idx);
    req_t item;
    item.cmd        = cmd;
    item.key        = key;
    item.slot_index = idx;
    return item;
  endfunction

  // Presents one command beat, with a random gap first, and waits for it to
  // be taken. Valid stays high afterwards so back-to-back beats need no drop.
  task automatic send_req(input req_t item);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    predict_command(item);
  endtask

  // Lets every outstanding result arrive, then allows for an ignored command
  // still being worked through.
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [TSIZE_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_tsize  = value;
  endtask

  // Keys: full range, small values, the extremes, and clusters on the modulus
  // so that probing chains form.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45) return KEY_W'($urandom_range(KEY_MAX));
    if (r < 65) return KEY_W'($urandom_range(300));
    if (r < 72) return KEY_MAX;
    if (r < 76) return '0;
    return KEY_W'($urandom_range(1023) * table_modulus() + $urandom_range(3));
  endfunction

  // Random mix of commands; ignored commands do not count towards the total.
  task automatic run_random(input int count, input int clear_pct);
    int   done, r;
    req_t item;
    done = 0;
    while (done < count) begin
      r    = $urandom_range(99);
      item = make_req(CMD_INSERT, pick_key(), SLOT_W'($urandom_range(127)));
      if (r < clear_pct) begin
        item.cmd = CMD_CLEAR;
      end else if (r < clear_pct + 6) begin
        item.cmd = CMD_NONE;
      end else if (r < 60) begin
        item.cmd = CMD_READ;
        if ($urandom_range(3) != 0) begin
          item.slot_index = SLOT_W'($urandom_range(table_modulus() - 1));
        end
      end
      send_req(item);
      if (item.cmd != CMD_NONE) done++;
    end
  endtask

  // Fresh table at the reset size: collisions on slot zero, key extremes,
  // an ignored command and a clear.
  task automatic test_after_reset();
    send_req(make_req(CMD_READ,   '0, 7'd0));
    send_req(make_req(CMD_READ,   KEY_MAX, 7'd127));
    send_req(make_req(CMD_INSERT, '0, '0));
    send_req(make_req(CMD_INSERT, 17'd127, '0));
    send_req(make_req(CMD_INSERT, KEY_MAX, 7'd127));
    send_req(make_req(CMD_INSERT, 17'd254, '0));
    send_req(make_req(CMD_READ,   '0, 7'd0));
    send_req(make_req(CMD_READ,   '0, 7'd1));
    send_req(make_req(CMD_READ,   '0, 7'd4));
    send_req(make_req(CMD_NONE,   KEY_MAX, 7'd127));
    send_req(make_req(CMD_CLEAR,  KEY_MAX, 7'd127));
    send_req(make_req(CMD_READ,   '0, 7'd0));
  endtask

  // Size register extremes: the smallest table fills and drops, out-of-range
  // sizes saturate, and slots beyond the size keep their contents.
  task automatic test_size_extremes();
    set_table_size(8'd2);
    send_req(make_req(CMD_INSERT, 17'd10, '0));
    send_req(make_req(CMD_INSERT, 17'd11, '0));
    send_req(make_req(CMD_INSERT, 17'd12, '0));
    send_req(make_req(CMD_READ,   '0, 7'd1));
    set_table_size(8'd0);
    send_req(make_req(CMD_INSERT, 17'd5, '0));
    send_req(make_req(CMD_CLEAR,  '0, '0));
    send_req(make_req(CMD_INSERT, 17'd1, '0));
    set_table_size(8'd255);
    send_req(make_req(CMD_INSERT, KEY_MAX, '0));
    send_req(make_req(CMD_READ,   '0, 7'd127));
    set_table_size(8'd1);
    send_req(make_req(CMD_INSERT, 17'd7, '0));
    send_req(make_req(CMD_READ,   '0, 7'd127));
    send_req(make_req(CMD_READ,   '0, 7'd0));
  endtask

  // Prime sizes, where placement always succeeds below half load.
  task automatic test_prime_tables();
    set_table_size(8'd127);
    run_random(60, 3);
    set_table_size(8'd7);
    run_random(60, 5);
    set_table_size(8'd31);
    run_random(60, 3);
    set_table_size(8'd101);
    run_random(60, 2);
    set_table_size(8'd13);
    run_random(60, 4);
  endtask

  // Boundary and out-of-range sizes, including full tables that drop.
  task automatic test_boundary_tables();
    set_table_size(8'd2);
    run_random(30, 5);
    set_table_size(8'd3);
    run_random(30, 5);
    set_table_size(8'd128);
    run_random(30, 2);
    set_table_size(8'd0);
    run_random(30, 5);
    set_table_size(8'd255);
    run_random(30, 2);
    set_table_size(8'd1);
    run_random(30, 5);
    set_table_size(8'd129);
    run_random(30, 2);
  endtask

  // A long stretch with both channels running flat out.
  task automatic test_no_idling();
    set_table_size(TSIZE_W'($urandom_range(2, 128)));
    calm = 1'b1;
    run_random(140, 3);
    settle();
    calm = 1'b0;
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result beat expected none actual status %0d slot %0d",
                 $time, rsp.status, rsp.slot);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status",     32'(want.status),     32'(rsp.status));
        check_field("slot",       32'(want.slot),       32'(rsp.slot));
        check_field("occupied",   32'(want.occupied),   32'(rsp.occupied));
        check_field("stored_key", 32'(want.stored_key), 32'(rsp.stored_key));
      end
    end
  end

  initial begin
    empty_shadow();
    shadow_tsize = TSIZE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_size_extremes();
    test_prime_tables();
    test_boundary_tables();
    test_no_idling();
    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/qph_pkg.sv
sv/qph_ram.sv
sv/qph_rem.sv
sv/quadratic_probe_hash_insert.sv
tb/quadratic_probe_hash_insert_test.sv
